@@ src/mcrt_pkg.sv @@
// Shared types, codes and helpers for the multi-channel reload timer unit.
package mcrt_pkg;

    localparam int NUM_CHANNELS  = 9;
    localparam int NUM_PRESCALED = 3;
    localparam int COUNT_WIDTH   = 32;

    localparam int DATA_WIDTH = 32;
    localparam int IRQ_WIDTH  = 9;
    localparam int DIV_WIDTH  = 8;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] REG_RELOAD  = 2'd0;
    localparam logic [1:0] REG_COUNT   = 2'd1;
    localparam logic [1:0] REG_CONTROL = 2'd2;
    localparam logic [1:0] REG_RUN     = 2'd3;

    localparam logic [1:0] PRE_DIV4   = 2'd0;
    localparam logic [1:0] PRE_DIV16  = 2'd1;
    localparam logic [1:0] PRE_DIV64  = 2'd2;
    localparam logic [1:0] PRE_DIV256 = 2'd3;

    localparam int CTL_IRQ_EN_BIT = 3;
    localparam int CTL_FLAG_BIT   = 4;

    typedef struct packed {
        logic [1:0]            operation;
        logic [3:0]            channel;
        logic [1:0]            reg_select;
        logic [DATA_WIDTH-1:0] write_data;
        logic                  tclk_edge;
    } request_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic [IRQ_WIDTH-1:0]  irq_lines;
        logic                  access_error;
    } result_t;

    typedef struct packed {
        logic                  tick;
        logic                  tclk_edge;
        logic [DIV_WIDTH-1:0]  div_next;
        logic                  wr;
        logic [1:0]            reg_select;
        logic [DATA_WIDTH-1:0] write_data;
    } chan_cmd_t;

    typedef struct packed {
        logic                  irq;
        logic [DATA_WIDTH-1:0] rd_word;
    } chan_stat_t;

    // True when the new divider value closes a prescale period for the code.
    function automatic logic prescale_hit(input logic [DIV_WIDTH-1:0] div,
                                          input logic [1:0] code);
        logic hit;
        case (code)
            PRE_DIV4:   hit = (div[1:0] == 2'b00);
            PRE_DIV16:  hit = (div[3:0] == 4'b0000);
            PRE_DIV64:  hit = (div[5:0] == 6'b000000);
            PRE_DIV256: hit = (div[7:0] == 8'b00000000);
            default:    hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

@@ src/mcrt_prescaler.sv @@
// Free-running prescale divider shared by the prescaled channels.
module mcrt_prescaler
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick,
    output logic [mcrt_pkg::DIV_WIDTH-1:0] div_next
);

    logic [mcrt_pkg::DIV_WIDTH-1:0] div_reg;

    assign div_next = div_reg + mcrt_pkg::DIV_WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= '0;
        end
        else if (tick)
        begin
            div_reg <= div_next;
        end
    end

endmodule

@@ src/mcrt_channel.sv @@
// One timer channel: counter, reload, control bits and underflow flag.
module mcrt_channel #(
    parameter int COUNT_WIDTH = mcrt_pkg::COUNT_WIDTH,
    parameter bit PRESCALED   = 1'b0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mcrt_pkg::chan_cmd_t cmd,
    output mcrt_pkg::chan_stat_t stat
);

    logic [COUNT_WIDTH-1:0] count_reg,  count_next;
    logic [COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic [1:0]             code_reg,   code_next;
    logic                   run_reg,    run_next;
    logic                   en_reg,     en_next;
    logic                   flag_reg,   flag_next;
    logic                   go;
    logic [1:0]             code_rd;

    always_comb
    begin
        if (PRESCALED)
        begin
            go = mcrt_pkg::prescale_hit(cmd.div_next, code_reg);
        end
        else
        begin
            go = cmd.tclk_edge;
        end
        go = go && run_reg && cmd.tick;
    end

    always_comb
    begin
        count_next  = count_reg;
        reload_next = reload_reg;
        code_next   = code_reg;
        run_next    = run_reg;
        en_next     = en_reg;
        flag_next   = flag_reg;
        if (go)
        begin
            // Count through zero: reload and mark the underflow.
            if (count_reg == '0)
            begin
                count_next = reload_reg;
                flag_next  = 1'b1;
            end
            else
            begin
                count_next = count_reg - COUNT_WIDTH'(1);
            end
        end
        else if (cmd.wr)
        begin
            case (cmd.reg_select)
                mcrt_pkg::REG_RELOAD: reload_next = cmd.write_data[COUNT_WIDTH-1:0];
                mcrt_pkg::REG_COUNT:  count_next  = cmd.write_data[COUNT_WIDTH-1:0];
                mcrt_pkg::REG_CONTROL:
                begin
                    if (PRESCALED)
                    begin
                        code_next = cmd.write_data[1:0];
                    end
                    en_next = cmd.write_data[mcrt_pkg::CTL_IRQ_EN_BIT];
                    if (!cmd.write_data[mcrt_pkg::CTL_FLAG_BIT])
                    begin
                        flag_next = 1'b0;
                    end
                end
                mcrt_pkg::REG_RUN:    run_next = cmd.write_data[0];
                default:              run_next = run_reg;
            endcase
        end
    end

    assign code_rd = PRESCALED ? code_reg : 2'b00;

    always_comb
    begin
        stat.irq = flag_next && en_next;
        case (cmd.reg_select)
            mcrt_pkg::REG_RELOAD:
                stat.rd_word = mcrt_pkg::DATA_WIDTH'(reload_reg);
            mcrt_pkg::REG_COUNT:
                stat.rd_word = mcrt_pkg::DATA_WIDTH'(count_reg);
            mcrt_pkg::REG_CONTROL:
                stat.rd_word = mcrt_pkg::DATA_WIDTH'({flag_reg, en_reg, 1'b0, code_rd});
            mcrt_pkg::REG_RUN:
                stat.rd_word = mcrt_pkg::DATA_WIDTH'(run_reg);
            default:
                stat.rd_word = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '1;
            reload_reg <= '1;
            code_reg   <= '0;
            run_reg    <= 1'b0;
            en_reg     <= 1'b0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            reload_reg <= reload_next;
            code_reg   <= code_next;
            run_reg    <= run_next;
            en_reg     <= en_next;
            flag_reg   <= flag_next;
        end
    end

endmodule

@@ src/multi_channel_reload_timer_unit.sv @@
// Top level of the multi-channel reload timer unit.
// A request transfer passes the input register, then the result register, and
// waits while the result side stalls. Throughput: one request per cycle
// unless the result side stalls; channel state updates in the single pass.
// Reset (rst_n low, asynchronous): counters and reloads go to all ones, control,
// run and flag bits and the prescale divider clear, both stages empty.
module multi_channel_reload_timer_unit #(
    parameter int NUM_CHANNELS  = mcrt_pkg::NUM_CHANNELS,
    parameter int NUM_PRESCALED = mcrt_pkg::NUM_PRESCALED,
    parameter int COUNT_WIDTH   = mcrt_pkg::COUNT_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_stall,
    input  mcrt_pkg::request_t request,
    output logic               result_valid,
    input  logic               result_stall,
    output mcrt_pkg::result_t  result
);

    localparam logic [4:0] NUM_CH = 5'(NUM_CHANNELS);

    // Input register: holds the request under work this cycle.
    logic               s1_valid_reg;
    mcrt_pkg::request_t s1_item_reg;

    // Result register: holds the finished result until its transfer.
    logic               out_valid_reg;
    mcrt_pkg::result_t  out_item_reg;

    logic               advance;
    logic               s1_load;
    logic               fire;
    logic               ch_ok;
    logic               is_tick;
    logic               is_write;
    logic               is_read;
    logic [mcrt_pkg::DATA_WIDTH-1:0] rd_sel;
    logic [mcrt_pkg::IRQ_WIDTH-1:0]  irq_vec;
    mcrt_pkg::result_t  res_next;
    logic [mcrt_pkg::DIV_WIDTH-1:0]  div_next;

    mcrt_pkg::chan_cmd_t  cmd  [NUM_CHANNELS];
    mcrt_pkg::chan_stat_t stat [NUM_CHANNELS];

    // Advance the result register whenever it is free or being emptied this
    // cycle. Load the input register when it is empty or moving on; stall the
    // requester only when it holds a request that cannot move.
    assign advance       = !out_valid_reg || !result_stall;
    assign s1_load       = !s1_valid_reg || advance;
    assign fire          = s1_valid_reg && advance;
    assign request_stall = !s1_load;
    assign result_valid  = out_valid_reg;
    assign result        = out_item_reg;

    assign ch_ok    = {1'b0, s1_item_reg.channel} < NUM_CH;
    assign is_tick  = s1_item_reg.operation == mcrt_pkg::OP_TICK;
    assign is_write = (s1_item_reg.operation == mcrt_pkg::OP_WRITE) && ch_ok;
    assign is_read  = (s1_item_reg.operation == mcrt_pkg::OP_READ) && ch_ok;

    mcrt_prescaler u_prescaler
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (fire && is_tick),
        .div_next (div_next)
    );

    // One channel per index; the low channels count through the prescaler.
    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_chan
        always_comb
        begin
            cmd[c].tick       = fire && is_tick;
            cmd[c].tclk_edge  = s1_item_reg.tclk_edge;
            cmd[c].div_next   = div_next;
            cmd[c].wr         = fire && is_write && (s1_item_reg.channel == 4'(c));
            cmd[c].reg_select = s1_item_reg.reg_select;
            cmd[c].write_data = s1_item_reg.write_data;
        end

        mcrt_channel #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .PRESCALED   (c < NUM_PRESCALED)
        ) u_chan
        (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd[c]),
            .stat  (stat[c])
        );
    end

    // AND-OR select of the addressed channel's read word.
    always_comb
    begin
        rd_sel = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (s1_item_reg.channel == 4'(c))
            begin
                rd_sel = rd_sel | stat[c].rd_word;
            end
        end
    end

    // Interrupt lines reflect the state after this item; channels past the
    // line count have no line, missing channels drive zero.
    always_comb
    begin
        irq_vec = '0;
        for (int c = 0; c < mcrt_pkg::IRQ_WIDTH; c++)
        begin
            if (c < NUM_CHANNELS)
            begin
                irq_vec[c] = stat[c].irq;
            end
        end
    end

    always_comb
    begin
        res_next.read_data    = is_read ? rd_sel : '0;
        res_next.irq_lines    = irq_vec;
        res_next.access_error = !is_tick && !is_read && !is_write;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg  <= request_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_item_reg <= request;
        end
        if (fire)
        begin
            out_item_reg <= res_next;
        end
    end

endmodule

@@ src/mcrt_checker.sv @@
// Port-level checks for the multi-channel reload timer unit, bound to the top.
module mcrt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               request_valid,
    input logic               request_stall,
    input mcrt_pkg::request_t request,
    input logic               result_valid,
    input logic               result_stall,
    input mcrt_pkg::result_t  result
);

    // Hold a stalled result.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Stall the request side only when the result side is full and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        request_stall |-> result_valid && result_stall)
        else $error("request stalled without result backpressure");

    // A result appearing from empty comes from an earlier request transfer through the input register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(request_valid && !request_stall, 2))
        else $error("result without matching request transfer");

    // Drop read data on a rejected access.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.access_error |-> result.read_data == '0)
        else $error("read data on access error");

endmodule

bind multi_channel_reload_timer_unit mcrt_checker u_mcrt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
);
